@@ design/wgm_pkg.sv @@
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types and constants for the wildcard glob matcher.
// ----------------------------------------------------------------------------
package wgm_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int CHAR_BITS_DEF   = 16;
    localparam int SYMBOL_W        = 16;
    localparam int WIDE_W          = 32;

    localparam logic [WIDE_W-1:0] STAR_CODE     = 32'd42;
    localparam logic [WIDE_W-1:0] QUESTION_CODE = 32'd63;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_TEXT   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic clear;     // drop the whole pattern
        logic load;      // append into the cell at the current length
        logic restart;   // live column back to start column
        logic step;      // advance live column by one text character
        logic sym_star;  // symbol is the star code
        logic sym_quest; // symbol is the question code
    } cell_ctrl_t;

    typedef struct packed {
        logic matched;
        logic text_end;
        logic pattern_overflow;
    } result_t;

endpackage

@@ design/wgm_cell.sv @@
// ----------------------------------------------------------------------------
// wgm_cell
// One pattern position: stored character plus its start and live column bits.
// ----------------------------------------------------------------------------
module wgm_cell
    import wgm_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int CHAR_BITS = CHAR_BITS_DEF,
    parameter int LEN_W     = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_ctrl_t           ctrl,
    input  logic [CHAR_BITS-1:0] symbol,
    input  logic [LEN_W-1:0]     length,
    input  logic                 start_in,
    input  logic                 live_in,
    input  logic                 carry_in,
    output logic                 start_out,
    output logic                 live_out,
    output logic                 carry_out,
    output logic                 tail_start,
    output logic                 tail_live,
    output logic                 tail_next
);

    localparam logic [LEN_W-1:0] MY_POS   = LEN_W'(IDX);
    localparam logic [LEN_W-1:0] TAIL_POS = LEN_W'(IDX + 1);

    logic                 occupied_reg, occupied_next;
    logic                 start_reg, start_next;
    logic                 live_reg, live_next;
    logic [CHAR_BITS-1:0] char_reg;
    logic                 star_reg;
    logic                 quest_reg;

    logic here;
    logic is_tail;
    logic next_bit;
    logic new_start;

    assign here    = (length == MY_POS);
    assign is_tail = (length == TAIL_POS);

    // one column step; star cells chain the carry from their left neighbor
    assign next_bit = occupied_reg &
                      (star_reg ? (live_reg | carry_in)
                                : (live_in & (quest_reg | (char_reg == symbol))));

    assign new_start = start_in & ctrl.sym_star;

    always_comb
    begin
        occupied_next = occupied_reg;
        start_next    = start_reg;
        live_next     = live_reg;
        priority if (ctrl.clear)
        begin
            occupied_next = 1'b0;
            start_next    = 1'b0;
            live_next     = 1'b0;
        end
        else if (ctrl.load && here)
        begin
            occupied_next = 1'b1;
            start_next    = new_start;
            live_next     = new_start;
        end
        else if (ctrl.restart)
        begin
            live_next = start_reg;
        end
        else if (ctrl.step)
        begin
            live_next = next_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg <= 1'b0;
            start_reg    <= 1'b0;
            live_reg     <= 1'b0;
        end
        else
        begin
            occupied_reg <= occupied_next;
            start_reg    <= start_next;
            live_reg     <= live_next;
        end
    end

    // character store, no reset
    always_ff @(posedge clk)
    begin
        if (ctrl.load && here)
        begin
            char_reg  <= symbol;
            star_reg  <= ctrl.sym_star;
            quest_reg <= ctrl.sym_quest;
        end
    end

    assign start_out  = start_reg;
    assign live_out   = live_reg;
    assign carry_out  = next_bit;
    assign tail_start = is_tail & start_reg;
    assign tail_live  = is_tail & live_reg;
    assign tail_next  = is_tail & next_bit;

endmodule

@@ design/wgm_out_buf.sv @@
// ----------------------------------------------------------------------------
// wgm_out_buf
// Output register with a skid stage so the stall toward the source is registered.
// ----------------------------------------------------------------------------
module wgm_out_buf
    import wgm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    input  result_t push_data,
    output logic    push_stall,
    output logic    pop_valid,
    output result_t pop_data,
    input  logic    pop_stall
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    push;
    logic    out_free;

    assign push_stall = skid_valid_reg;
    assign push       = push_valid & ~skid_valid_reg;
    assign out_free   = ~out_valid_reg | ~pop_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = push;
                skid_next       = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_next       = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign pop_valid = out_valid_reg;
    assign pop_data  = out_reg;

endmodule

@@ design/wildcard_glob_matcher.sv @@
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// Streaming '*' / '?' matcher built as a row of pattern cells.
// ----------------------------------------------------------------------------
//
//  channel | signals                           | direction
//  --------+-----------------------------------+----------
//  item    | item_valid, item_stall,           | in
//          | action, symbol, last              |
//  result  | result_valid, result_stall,       | out
//          | matched, text_end,                |
//          | pattern_overflow                  |
//
//  one transaction per cycle in both directions while neither side stalls; a result
//  goes to the output register, or to the skid entry while the output is stalled
//  the cell row updates its whole column in the accept cycle; the star
//  carry ripples through the cells within that cycle
//  reset leaves an empty pattern and an empty text string, no clearing pass
//  a two-entry output buffer absorbs result stalls; item_stall rises only
//  when both entries are full
// ----------------------------------------------------------------------------
module wildcard_glob_matcher
    import wgm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int CHAR_BITS   = CHAR_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [1:0]          action,
    input  logic [SYMBOL_W-1:0] symbol,
    input  logic                last,
    output logic                result_valid,
    input  logic                result_stall,
    output logic                matched,
    output logic                text_end,
    output logic                pattern_overflow
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(MAX_PATTERN);

    // pattern length and the column bit for the empty prefix
    logic [LEN_W-1:0] length_reg, length_next;
    logic             live0_reg, live0_next;

    logic                 accept;
    action_t              act;
    logic [WIDE_W-1:0]    sym_wide;
    logic [CHAR_BITS-1:0] sym;
    logic                 full;
    cell_ctrl_t           ctrl;
    result_t              res;

    // neighbor links, index 0 is the empty-prefix position
    logic [MAX_PATTERN:0]   start_w;
    logic [MAX_PATTERN:0]   live_w;
    logic [MAX_PATTERN:0]   carry_w;
    logic [MAX_PATTERN-1:0] tail_start_w;
    logic [MAX_PATTERN-1:0] tail_live_w;
    logic [MAX_PATTERN-1:0] tail_next_w;

    logic tail_start_any;
    logic tail_live_any;
    logic tail_next_any;
    logic start_at_len;

    assign accept   = item_valid & ~item_stall;
    assign act      = action_t'(action);
    assign sym_wide = WIDE_W'(symbol);
    assign sym      = sym_wide[CHAR_BITS-1:0];
    assign full     = (length_reg == FULL_LEN);

    // control broadcast to the cell row
    always_comb
    begin
        ctrl           = '0;
        ctrl.sym_star  = (sym_wide[CHAR_BITS-1:0] == STAR_CODE[CHAR_BITS-1:0]);
        ctrl.sym_quest = (sym_wide[CHAR_BITS-1:0] == QUESTION_CODE[CHAR_BITS-1:0]);
        if (accept)
        begin
            unique case (act)
                ACT_CLEAR:
                begin
                    ctrl.clear = 1'b1;
                end
                ACT_APPEND:
                begin
                    ctrl.load    = ~full;
                    ctrl.restart = 1'b1;
                end
                ACT_TEXT:
                begin
                    ctrl.restart = last;
                    ctrl.step    = ~last;
                end
                ACT_NONE:
                begin
                    ctrl.clear = 1'b0;
                end
                default:
                begin
                    ctrl.clear = 1'b0;
                end
            endcase
        end
    end

    // empty prefix: start bit is always set, live bit is kept here
    assign start_w[0] = 1'b1;
    assign live_w[0]  = live0_reg;
    assign carry_w[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++)
        begin : g_cell
            wgm_cell #(
                .IDX       (gi),
                .CHAR_BITS (CHAR_BITS),
                .LEN_W     (LEN_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .symbol     (sym),
                .length     (length_reg),
                .start_in   (start_w[gi]),
                .live_in    (live_w[gi]),
                .carry_in   (carry_w[gi]),
                .start_out  (start_w[gi+1]),
                .live_out   (live_w[gi+1]),
                .carry_out  (carry_w[gi+1]),
                .tail_start (tail_start_w[gi]),
                .tail_live  (tail_live_w[gi]),
                .tail_next  (tail_next_w[gi])
            );
        end
    endgenerate

    // only the cell at the pattern end reports, so a plain OR picks it
    assign tail_start_any = |tail_start_w;
    assign tail_live_any  = |tail_live_w;
    assign tail_next_any  = |tail_next_w;
    assign start_at_len   = (length_reg == '0) ? 1'b1 : tail_start_any;

    // result of the current transaction
    always_comb
    begin
        res = '0;
        unique case (act)
            ACT_CLEAR:
            begin
                res.matched = 1'b1;
            end
            ACT_APPEND:
            begin
                if (full)
                begin
                    res.matched          = tail_start_any;
                    res.pattern_overflow = 1'b1;
                end
                else
                begin
                    res.matched = start_at_len & ctrl.sym_star;
                end
            end
            ACT_TEXT:
            begin
                res.matched  = tail_next_any;
                res.text_end = last;
            end
            ACT_NONE:
            begin
                res.matched = (length_reg == '0) ? live0_reg : tail_live_any;
            end
            default:
            begin
                res.matched = 1'b0;
            end
        endcase
    end

    // length counter and empty-prefix live bit
    always_comb
    begin
        length_next = length_reg;
        live0_next  = live0_reg;
        if (accept)
        begin
            unique case (act)
                ACT_CLEAR:
                begin
                    length_next = '0;
                    live0_next  = 1'b1;
                end
                ACT_APPEND:
                begin
                    if (!full)
                    begin
                        length_next = length_reg + LEN_W'(1);
                    end
                    live0_next = 1'b1;
                end
                ACT_TEXT:
                begin
                    live0_next = last;
                end
                ACT_NONE:
                begin
                    live0_next = live0_reg;
                end
                default:
                begin
                    live0_next = live0_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
            live0_reg  <= 1'b1;
        end
        else
        begin
            length_reg <= length_next;
            live0_reg  <= live0_next;
        end
    end

    // output register plus skid entry
    result_t out_data;

    wgm_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (item_valid),
        .push_data  (res),
        .push_stall (item_stall),
        .pop_valid  (result_valid),
        .pop_data   (out_data),
        .pop_stall  (result_stall)
    );

    assign matched          = out_data.matched;
    assign text_end         = out_data.text_end;
    assign pattern_overflow = out_data.pattern_overflow;

endmodule
